// ----- hw/rtl/chm_pkg.sv -----
// chm_pkg: shared types and constants of the chained hash map unit
// no dependencies
`timescale 1ns / 1ps

package chm_pkg;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int CFG_W  = 9;
    localparam int DIV_W  = 9;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_PUT    = 2'd1,
        OP_TRYPUT = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HEAD_RD,
        ST_HEAD_WT,
        ST_NODE_RD,
        ST_NODE_WT,
        ST_DECIDE,
        ST_FREE_RD,
        ST_FREE_WT,
        ST_LINK,
        ST_OUT
    } t_state;

endpackage

// ----- hw/rtl/chm_ram.sv -----
// chm_ram: generic single port write, single port registered read memory
// no dependencies
`timescale 1ns / 1ps

module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/chm_mod.sv -----
// chm_mod: bit serial remainder of a 64-bit key by the bucket count
// depends on chm_pkg
`timescale 1ns / 1ps

module chm_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [chm_pkg::KEY_W-1:0] i_key,
    input  logic [chm_pkg::DIV_W-1:0] i_div,
    output logic                      o_done,
    output logic [chm_pkg::DIV_W-1:0] o_rem
);

    logic [chm_pkg::KEY_W-1:0] r_key, n_key;
    logic [chm_pkg::DIV_W:0]   r_rem, n_rem;
    logic [6:0]                r_cnt, n_cnt;
    logic                      r_busy, n_busy;
    logic [chm_pkg::DIV_W:0]   w_sh;

    always_comb begin
        n_key  = r_key;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_sh   = {r_rem[chm_pkg::DIV_W-1:0], r_key[chm_pkg::KEY_W-1]};
        if (i_start) begin
            n_key  = i_key;
            n_rem  = '0;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_key = {r_key[chm_pkg::KEY_W-2:0], 1'b0};
            n_rem = (w_sh >= {1'b0, i_div}) ? w_sh - {1'b0, i_div} : w_sh;
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'(chm_pkg::KEY_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_key <= n_key;
        r_rem <= n_rem;
    end

    assign o_done = r_busy && (r_cnt == 7'(chm_pkg::KEY_W - 1));
    assign o_rem  = n_rem[chm_pkg::DIV_W-1:0];

endmodule

// ----- hw/rtl/chained_hash_map_unit.sv -----
// chained hash map unit: modulo hashed separate chaining key-value map
// steps: serial modulo, bucket head read, a node read per link visited, a last
//   check on a miss, a decide step, then free list pop and link write for an insert
// flow: one word in flight, the next taken in the cycle after the result leaves
// reset: a clearing pass over max(BUCKETS, NODES) entries; no word accepted before it ends
// depends on chm_pkg, chm_ram, chm_mod
`timescale 1ns / 1ps

module chained_hash_map_unit #(
    parameter int BUCKETS = 256,
    parameter int NODES   = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [chm_pkg::CFG_W-1:0] i_bucket_count,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_opcode,
    input  logic [chm_pkg::KEY_W-1:0] i_key,
    input  logic [chm_pkg::VAL_W-1:0] i_value_in,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [chm_pkg::VAL_W-1:0] o_value_out,
    output logic                      o_found,
    output logic                      o_status
);

    localparam int NW  = $clog2(NODES + 1);
    localparam int NA  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int BA  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CLR = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CW  = $clog2(CLR + 1);
    localparam logic [NW-1:0] NIL = NW'(NODES);

    chm_pkg::t_state r_st, n_st;

    logic [chm_pkg::CFG_W-1:0] r_bcnt;
    logic [CW-1:0]             r_clr, n_clr;
    chm_pkg::t_op              r_op, n_op;
    logic [chm_pkg::KEY_W-1:0] r_key, n_key;
    logic [chm_pkg::VAL_W-1:0] r_val, n_val;
    logic [BA-1:0]             r_b, n_b;
    logic [NW-1:0]             r_cur, n_cur;
    logic [NW-1:0]             r_pred, n_pred;
    logic [NW-1:0]             r_hnext, n_hnext;
    logic [NW:0]               r_steps, n_steps;
    logic                      r_hit, n_hit;
    logic [NW-1:0]             r_free, n_free;
    logic [NW-1:0]             r_newn, n_newn;
    logic [chm_pkg::VAL_W-1:0] r_vout, n_vout;
    logic                      r_found, n_found;
    logic                      r_stat, n_stat;

    logic [chm_pkg::DIV_W-1:0] w_div;
    logic                      w_mdone;
    logic [chm_pkg::DIV_W-1:0] w_rem;

    logic          w_hd_we;
    logic [BA-1:0] w_hd_wa, w_hd_ra;
    logic [NW-1:0] w_hd_wd, w_hd_rd;
    logic          w_nd_we;
    logic [NA-1:0] w_nd_wa, w_nd_ra;
    logic [NW-1:0] w_nx_wd, w_nx_rd;
    logic [chm_pkg::KEY_W-1:0] w_nk_wd, w_nk_rd;
    logic [chm_pkg::VAL_W-1:0] w_nv_wd, w_nv_rd;
    logic          w_nx_we;
    logic [NA-1:0] w_nx_wa;
    logic          w_fs_we;
    logic [NA-1:0] w_fs_wa, w_fs_ra;
    logic [NA-1:0] w_fs_wd, w_fs_rd;

    always_comb begin
        if (r_bcnt == '0) begin
            w_div = chm_pkg::DIV_W'(1);
        end else if (32'(r_bcnt) > BUCKETS) begin
            w_div = chm_pkg::DIV_W'(BUCKETS);
        end else begin
            w_div = r_bcnt;
        end
    end

    chm_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_st == chm_pkg::ST_IDLE && i_valid),
        .i_key   (i_key),
        .i_div   (w_div),
        .o_done  (w_mdone),
        .o_rem   (w_rem)
    );

    chm_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(w_hd_we), .i_waddr(w_hd_wa), .i_wdata(w_hd_wd),
        .i_raddr(w_hd_ra), .o_rdata(w_hd_rd)
    );
    chm_ram #(.WIDTH(chm_pkg::KEY_W), .DEPTH(NODES)) u_nkey (
        .i_clk(i_clk), .i_we(w_nd_we), .i_waddr(w_nd_wa), .i_wdata(w_nk_wd),
        .i_raddr(w_nd_ra), .o_rdata(w_nk_rd)
    );
    chm_ram #(.WIDTH(chm_pkg::VAL_W), .DEPTH(NODES)) u_nval (
        .i_clk(i_clk), .i_we(w_nd_we), .i_waddr(w_nd_wa), .i_wdata(w_nv_wd),
        .i_raddr(w_nd_ra), .o_rdata(w_nv_rd)
    );
    chm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_nnext (
        .i_clk(i_clk), .i_we(w_nx_we), .i_waddr(w_nx_wa), .i_wdata(w_nx_wd),
        .i_raddr(w_nd_ra), .o_rdata(w_nx_rd)
    );
    chm_ram #(.WIDTH(NA), .DEPTH(NODES)) u_free (
        .i_clk(i_clk), .i_we(w_fs_we), .i_waddr(w_fs_wa), .i_wdata(w_fs_wd),
        .i_raddr(w_fs_ra), .o_rdata(w_fs_rd)
    );

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            chm_pkg::ST_CLEAR:   if (r_clr == CW'(CLR - 1)) n_st = chm_pkg::ST_IDLE;
            chm_pkg::ST_IDLE:    if (i_valid) n_st = chm_pkg::ST_HASH;
            chm_pkg::ST_HASH:    if (w_mdone) n_st = chm_pkg::ST_HEAD_RD;
            chm_pkg::ST_HEAD_RD: n_st = chm_pkg::ST_HEAD_WT;
            chm_pkg::ST_HEAD_WT: n_st = chm_pkg::ST_NODE_RD;
            chm_pkg::ST_NODE_RD: begin
                if (r_cur >= NIL || r_steps >= (NW + 1)'(NODES)) begin
                    n_st = chm_pkg::ST_DECIDE;
                end else begin
                    n_st = chm_pkg::ST_NODE_WT;
                end
            end
            chm_pkg::ST_NODE_WT: begin
                if (w_nk_rd == r_key) begin
                    n_st = chm_pkg::ST_DECIDE;
                end else begin
                    n_st = chm_pkg::ST_NODE_RD;
                end
            end
            chm_pkg::ST_DECIDE: begin
                if (r_op == chm_pkg::OP_PUT
                    || (r_op == chm_pkg::OP_TRYPUT && !r_hit)) begin
                    n_st = (r_free == '0 || r_free > NIL)
                        ? chm_pkg::ST_OUT : chm_pkg::ST_FREE_RD;
                end else begin
                    n_st = chm_pkg::ST_OUT;
                end
            end
            chm_pkg::ST_FREE_RD: n_st = chm_pkg::ST_FREE_WT;
            chm_pkg::ST_FREE_WT: n_st = chm_pkg::ST_LINK;
            chm_pkg::ST_LINK:    n_st = chm_pkg::ST_OUT;
            chm_pkg::ST_OUT:     if (i_ready) n_st = chm_pkg::ST_IDLE;
            default:             n_st = chm_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_clr   = r_clr;
        n_op    = r_op;
        n_key   = r_key;
        n_val   = r_val;
        n_b     = r_b;
        n_cur   = r_cur;
        n_pred  = r_pred;
        n_hnext = r_hnext;
        n_steps = r_steps;
        n_hit   = r_hit;
        n_free  = r_free;
        n_newn  = r_newn;
        n_vout  = r_vout;
        n_found = r_found;
        n_stat  = r_stat;

        w_hd_we = 1'b0;
        w_hd_wa = r_b;
        w_hd_wd = NIL;
        w_hd_ra = r_b;
        w_nd_we = 1'b0;
        w_nd_wa = r_newn[NA-1:0];
        w_nd_ra = r_cur[NA-1:0];
        w_nk_wd = r_key;
        w_nv_wd = r_val;
        w_nx_we = 1'b0;
        w_nx_wa = r_newn[NA-1:0];
        w_nx_wd = w_hd_rd;
        w_fs_we = 1'b0;
        w_fs_wa = r_free[NA-1:0];
        w_fs_wd = r_cur[NA-1:0];
        w_fs_ra = NA'(r_free - NW'(1));

        case (r_st)
            chm_pkg::ST_CLEAR: begin
                n_clr = r_clr + CW'(1);
                if (32'(r_clr) < BUCKETS) begin
                    w_hd_we = 1'b1;
                    w_hd_wa = BA'(r_clr);
                end
                if (32'(r_clr) < NODES) begin
                    w_fs_we = 1'b1;
                    w_fs_wa = NA'(r_clr);
                    w_fs_wd = NA'(CW'(NODES - 1) - r_clr);
                end
            end
            chm_pkg::ST_IDLE: begin
                n_op    = chm_pkg::t_op'(i_opcode);
                n_key   = i_key;
                n_val   = i_value_in;
                n_steps = '0;
                n_hit   = 1'b0;
                n_pred  = NIL;
            end
            chm_pkg::ST_HASH: begin
                n_b = BA'(w_rem);
            end
            chm_pkg::ST_HEAD_WT: begin
                n_cur   = w_hd_rd;
                n_hnext = w_hd_rd;
            end
            chm_pkg::ST_NODE_WT: begin
                if (w_nk_rd == r_key) begin
                    n_hit   = 1'b1;
                    n_vout  = w_nv_rd;
                    n_hnext = w_nx_rd;
                end else begin
                    n_pred  = r_cur;
                    n_cur   = w_nx_rd;
                    n_steps = r_steps + (NW + 1)'(1);
                end
            end
            chm_pkg::ST_DECIDE: begin
                n_found = r_hit;
                n_stat  = 1'b0;
                case (r_op)
                    chm_pkg::OP_GET: begin
                        if (!r_hit) n_vout = '0;
                    end
                    chm_pkg::OP_REMOVE: begin
                        if (!r_hit) begin
                            n_vout = '0;
                        end else begin
                            if (r_pred < NIL) begin
                                w_nx_we = 1'b1;
                                w_nx_wa = r_pred[NA-1:0];
                                w_nx_wd = r_hnext;
                            end else begin
                                w_hd_we = 1'b1;
                                w_hd_wd = r_hnext;
                            end
                            if (r_free < NIL) begin
                                w_fs_we = 1'b1;
                                n_free  = r_free + NW'(1);
                            end
                        end
                    end
                    chm_pkg::OP_TRYPUT: begin
                        if (!r_hit && (r_free == '0 || r_free > NIL)) begin
                            n_vout = '0;
                            n_stat = 1'b1;
                        end
                    end
                    default: begin
                        if (r_free == '0 || r_free > NIL) begin
                            n_vout = '0;
                            n_stat = 1'b1;
                        end
                    end
                endcase
            end
            chm_pkg::ST_FREE_RD: begin
                n_free = r_free - NW'(1);
            end
            chm_pkg::ST_FREE_WT: begin
                n_newn = {1'b0, w_fs_rd};
            end
            chm_pkg::ST_LINK: begin
                w_nd_we = 1'b1;
                w_nx_we = 1'b1;
                w_hd_we = 1'b1;
                w_hd_wd = r_newn;
                n_vout  = r_val;
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = (r_st == chm_pkg::ST_IDLE);
        o_cfg_ready = (r_st == chm_pkg::ST_IDLE && !i_valid) || (r_st == chm_pkg::ST_CLEAR);
        o_valid     = (r_st == chm_pkg::ST_OUT);
        o_value_out = r_vout;
        o_found     = r_found;
        o_status    = r_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= chm_pkg::ST_CLEAR;
            r_clr  <= '0;
            r_bcnt <= chm_pkg::CFG_W'(256);
            r_free <= NIL;
        end else begin
            r_st  <= n_st;
            r_clr <= n_clr;
            r_free <= n_free;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bcnt <= i_bucket_count;
            end
        end
        r_op    <= n_op;
        r_key   <= n_key;
        r_val   <= n_val;
        r_b     <= n_b;
        r_cur   <= n_cur;
        r_pred  <= n_pred;
        r_hnext <= n_hnext;
        r_steps <= n_steps;
        r_hit   <= n_hit;
        r_newn  <= n_newn;
        r_vout  <= n_vout;
        r_found <= n_found;
        r_stat  <= n_stat;
    end

endmodule

// ----- tb/sv/chained_hash_map_checker.sv -----
// chained_hash_map_checker: watches the request, response and config channels,
// predicts each response from its own copy of the map and compares field by field
// depends on chm_pkg
`timescale 1ns / 1ps

module chained_hash_map_checker #(
    parameter int BUCKETS = 256,
    parameter int NODES   = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [chm_pkg::CFG_W-1:0] i_bucket_count,
    input  logic                      i_valid,
    input  logic                      i_ready,
    input  logic [1:0]                i_opcode,
    input  logic [chm_pkg::KEY_W-1:0] i_key,
    input  logic [chm_pkg::VAL_W-1:0] i_value_in,
    input  logic                      i_rsp_valid,
    input  logic                      i_rsp_ready,
    input  logic [chm_pkg::VAL_W-1:0] i_value_out,
    input  logic                      i_found,
    input  logic                      i_status,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct packed {
        logic [chm_pkg::VAL_W-1:0] value;
        logic                      found;
        logic                      status;
    } t_rsp;

    localparam int NIL = NODES;

    t_rsp   rsp_q[$];
    int     divisor;
    int     head[BUCKETS];
    logic [chm_pkg::KEY_W-1:0] nkey[NODES];
    logic [chm_pkg::VAL_W-1:0] nval[NODES];
    int     nnext[NODES];
    int     free_stk[NODES];
    int     free_n;

    assign o_pending = rsp_q.size();

    function automatic int bucket_of(logic [chm_pkg::KEY_W-1:0] k);
        int n;
        n = divisor;
        if (n == 0) n = 1;
        if (n > BUCKETS) n = BUCKETS;
        return int'(k % 64'(n));
    endfunction

    function automatic t_rsp apply_op(chm_pkg::t_op op, logic [chm_pkg::KEY_W-1:0] k,
                                      logic [chm_pkg::VAL_W-1:0] v);
        t_rsp r;
        int b, cur, pred, hit, steps, n;
        bit ins;
        b = bucket_of(k);
        cur = head[b];
        pred = NIL;
        hit = NIL;
        steps = 0;
        while (cur < NIL && steps < NODES) begin
            if (nkey[cur] == k) begin
                hit = cur;
                break;
            end
            pred = cur;
            cur = nnext[cur];
            steps++;
        end
        r = '0;
        r.found = hit < NIL;
        ins = 0;
        case (op)
            chm_pkg::OP_GET: if (hit < NIL) r.value = nval[hit];
            chm_pkg::OP_PUT: ins = 1;
            chm_pkg::OP_TRYPUT: begin
                if (hit < NIL) r.value = nval[hit];
                else ins = 1;
            end
            default: begin
                if (hit < NIL) begin
                    r.value = nval[hit];
                    if (pred < NIL) nnext[pred] = nnext[hit];
                    else head[b] = nnext[hit];
                    if (free_n < NODES) begin
                        free_stk[free_n] = hit;
                        free_n++;
                    end
                end
            end
        endcase
        if (ins) begin
            if (free_n == 0) begin
                r.status = 1;
            end else begin
                free_n--;
                n = free_stk[free_n];
                nkey[n] = k;
                nval[n] = v;
                nnext[n] = head[b];
                head[b] = n;
                r.value = v;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            divisor <= 256;
            o_errors <= 0;
            free_n = NODES;
            for (int i = 0; i < BUCKETS; i++) head[i] = NIL;
            for (int i = 0; i < NODES; i++) begin
                nnext[i] = NIL;
                free_stk[i] = NODES - 1 - i;
            end
            rsp_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) divisor <= int'(i_bucket_count);
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected response value=%h", i_value_out);
                    o_errors <= o_errors + 1;
                end else begin
                    want = rsp_q.pop_front();
                    if (want.value !== i_value_out || want.found !== i_found
                            || want.status !== i_status) begin
                        if (o_errors < 10)
                            $display("exp value=%h found=%b status=%b got %h %b %b",
                                want.value, want.found, want.status,
                                i_value_out, i_found, i_status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_ready)
                rsp_q.push_back(apply_op(chm_pkg::t_op'(i_opcode), i_key, i_value_in));
        end
    end
endmodule

// ----- tb/sv/chained_hash_map_unit_tb.sv -----
// chained_hash_map_unit_tb: drives words and bucket counts into the map unit
// and reports the verdict; depends on chm_pkg, chained_hash_map_checker and the rtl
`timescale 1ns / 1ps

module chained_hash_map_unit_tb;

    logic i_clk, i_rst_n;
    logic cfg_valid, cfg_ready;
    logic [chm_pkg::CFG_W-1:0] bucket_count;
    logic in_valid, in_ready;
    logic [1:0] opcode;
    logic [chm_pkg::KEY_W-1:0] key;
    logic [chm_pkg::VAL_W-1:0] value_in;
    logic out_valid, out_ready;
    logic [chm_pkg::VAL_W-1:0] value_out;
    logic found, status;
    int errors, pending;
    bit quiet;
    logic [chm_pkg::KEY_W-1:0] recent[16];

    chained_hash_map_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_bucket_count(bucket_count),
        .i_valid(in_valid), .o_ready(in_ready), .i_opcode(opcode), .i_key(key),
        .i_value_in(value_in), .o_valid(out_valid), .i_ready(out_ready),
        .o_value_out(value_out), .o_found(found), .o_status(status)
    );

    chained_hash_map_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_bucket_count(bucket_count),
        .i_valid(in_valid), .i_ready(in_ready), .i_opcode(opcode), .i_key(key),
        .i_value_in(value_in), .i_rsp_valid(out_valid), .i_rsp_ready(out_ready),
        .i_value_out(value_out), .i_found(found), .i_status(status),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("Mismatches found");
        $finish;
    end

    // result side stalls in short bursts
    initial begin
        out_ready = 1;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(7) == 0) begin
                out_ready <= 0;
                repeat ($urandom_range(3, 1)) @(posedge i_clk);
                out_ready <= 1;
            end
        end
    end

    // valid stays up after an accept until the next word or a drain replaces it
    task automatic send(chm_pkg::t_op op, logic [chm_pkg::KEY_W-1:0] k,
                        logic [chm_pkg::VAL_W-1:0] v);
        if (!quiet && $urandom_range(5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        in_valid <= 1;
        opcode <= op;
        key <= k;
        value_in <= v;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_count(logic [chm_pkg::CFG_W-1:0] c);
        cfg_valid <= 1;
        bucket_count <= c;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int n, int keyspan);
        logic [chm_pkg::KEY_W-1:0] k;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(9);
            if (r == 0) k = rnd64();
            else if (r < 4) k = recent[$urandom_range(15)];
            else k = 64'($urandom_range(keyspan)) | (r == 9 ? 64'hFFFF_0000_0000_0000 : 0);
            recent[$urandom_range(15)] = k;
            send(chm_pkg::t_op'($urandom_range(3)), k, rnd64());
        end
    endtask

    initial begin
        int counts[6];
        quiet = 0;
        i_rst_n = 0;
        cfg_valid = 0;
        bucket_count = 0;
        in_valid = 0;
        opcode = chm_pkg::OP_GET;
        key = 0;
        value_in = 0;
        for (int i = 0; i < 16; i++) recent[i] = 64'(i);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        send(chm_pkg::OP_GET, 64'd0, 64'd0);
        send(chm_pkg::OP_PUT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send(chm_pkg::OP_PUT, 64'd0, 64'h1);
        send(chm_pkg::OP_GET, 64'd0, 64'd0);
        send(chm_pkg::OP_TRYPUT, 64'd0, 64'h5);
        send(chm_pkg::OP_TRYPUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5);
        send(chm_pkg::OP_PUT, 64'd256, 64'd7);
        send(chm_pkg::OP_PUT, 64'd512, 64'd8);
        send(chm_pkg::OP_REMOVE, 64'd0, 64'd0);
        send(chm_pkg::OP_GET, 64'd0, 64'd0);
        send(chm_pkg::OP_REMOVE, 64'd0, 64'd0);
        send(chm_pkg::OP_REMOVE, 64'd0, 64'd0);
        send(chm_pkg::OP_GET, 64'd256, 64'd0);
        send(chm_pkg::OP_REMOVE, 64'd12345, 64'd0);
        drain();
        // changed count leaves chains in place
        write_count(9'd0);
        send(chm_pkg::OP_GET, 64'd256, 64'd0);
        send(chm_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
        send(chm_pkg::OP_GET, 64'd512, 64'd0);
        drain();
        write_count(9'h1FF);
        send(chm_pkg::OP_GET, 64'd512, 64'd0);
        send(chm_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        drain();

        // fill the pool to hit the full status
        write_count(9'd256);
        for (int i = 0; i < 1030; i++) begin
            if (i == 1000) quiet = 1;
            send(chm_pkg::OP_PUT, 64'($urandom_range(4095)), rnd64());
        end
        send(chm_pkg::OP_TRYPUT, 64'h7777_7777, 64'd1);
        send(chm_pkg::OP_TRYPUT, key, 64'd2);
        quiet = 0;
        drain();
        for (int i = 0; i < 300; i++) begin
            send(chm_pkg::OP_REMOVE, 64'($urandom_range(4095)), 64'd0);
        end
        drain();

        counts = '{1, 256, 3, 17, 200, 64};
        for (int p = 0; p < 6; p++) begin
            write_count(chm_pkg::CFG_W'(counts[p]));
            random_phase(75, p < 3 ? 63 : 1023);
            if (p == 4) quiet = 1;
            drain();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- chained_hash_map_unit.f -----
hw/rtl/chm_pkg.sv
hw/rtl/chm_ram.sv
hw/rtl/chm_mod.sv
hw/rtl/chained_hash_map_unit.sv
tb/sv/chained_hash_map_checker.sv
tb/sv/chained_hash_map_unit_tb.sv
